[sv/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, codes and controller/datapath interface types for the
// fat tree next port selector.
// ----------------------------------------------------------------------------
package fts_pkg;

   // parameter defaults
   localparam int MAX_ARITY_DEF  = 16;
   localparam int NUM_QUEUES_DEF = 1024;
   localparam int HOST_BITS_DEF  = 10;

   // fixed field widths
   localparam int KIND_W     = 3;
   localparam int QUEUE_W    = 10;
   localparam int FLOW_W     = 32;
   localparam int PKT_W      = 2;
   localparam int SAVED_W    = 3;
   localparam int HOP_W      = 3;
   localparam int ACTION_W   = 2;
   localparam int PORT_W     = 4;
   localparam int ARITY_W    = 5;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // divider lanes
   localparam int SUM_W   = 32;
   localparam int STEPS_A = SUM_W / 2;
   localparam int NLANES  = 4;

   // link kinds
   localparam logic [KIND_W-1:0] LINK_HOST_EDGE = 3'd0;
   localparam logic [KIND_W-1:0] LINK_EDGE_AGG  = 3'd1;
   localparam logic [KIND_W-1:0] LINK_EDGE_HOST = 3'd2;
   localparam logic [KIND_W-1:0] LINK_AGG_EDGE  = 3'd3;
   localparam logic [KIND_W-1:0] LINK_AGG_CORE  = 3'd4;
   localparam logic [KIND_W-1:0] LINK_CORE_AGG  = 3'd5;

   // packet kinds
   localparam logic [PKT_W-1:0] PKT_PROBE = 2'd0;
   localparam logic [PKT_W-1:0] PKT_DATA  = 2'd2;

   // balance modes
   localparam logic [MODE_W-1:0] MODE_SPRAY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HASH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SAVED = 2'd3;

   // actions
   localparam logic [ACTION_W-1:0] ACT_FORWARD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ARRIVED  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MISMATCH = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_HOP_ERR  = 2'd3;

   // expected hop counts
   localparam logic [HOP_W-1:0] HOP_RACK = 3'd2;
   localparam logic [HOP_W-1:0] HOP_POD  = 3'd4;
   localparam logic [HOP_W-1:0] HOP_CORE = 3'd6;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ARITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'd1;
   localparam logic [ARITY_W-1:0]   ARITY_RESET = 5'd4;
   localparam logic [MODE_W-1:0]    MODE_RESET  = 2'd0;

   typedef struct packed {
      logic clear;
      logic capture;
      logic load_a;
      logic load_b;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

[sv/fts_ram.sv]
// ----------------------------------------------------------------------------
// fts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fts_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fts_ctrl.sv]
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer: clearing pass, capture, two divider passes and result hand-off.
// ----------------------------------------------------------------------------
module fts_ctrl #(
   parameter int HOST_BITS = fts_pkg::HOST_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fts_pkg::cmd_type    cmd,
   input  fts_pkg::status_type status
);

   localparam int STEPS_B = (HOST_BITS + 1) / 2;
   localparam int CNT_W   = $clog2(fts_pkg::STEPS_A);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_A,
      ST_RUN_A,
      ST_LOAD_B,
      ST_RUN_B,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_LOAD_A;
            end
         end
         ST_LOAD_A: begin
            cmd.load_a = 1'b1;
            cnt_in     = '0;
            state_in   = ST_RUN_A;
         end
         ST_RUN_A: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(fts_pkg::STEPS_A - 1)) begin
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            cmd.load_b = 1'b1;
            cnt_in     = '0;
            state_in   = ST_RUN_B;
         end
         ST_RUN_B: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS_B - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/fts_dpath.sv]
// ----------------------------------------------------------------------------
// fts_dpath
// Datapath: registers, four-lane radix-4 restoring divider by k/2,
// spray counter RAM and result selection.
// ----------------------------------------------------------------------------
module fts_dpath #(
   parameter int MAX_ARITY  = fts_pkg::MAX_ARITY_DEF,
   parameter int NUM_QUEUES = fts_pkg::NUM_QUEUES_DEF,
   parameter int HOST_BITS  = fts_pkg::HOST_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fts_pkg::cmd_type                 cmd,
   output fts_pkg::status_type              status,
   input  logic                             csr_wr_en,
   input  logic [fts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic [fts_pkg::KIND_W-1:0]       req_link_kind,
   input  logic [fts_pkg::QUEUE_W-1:0]      req_queue_id,
   input  logic [HOST_BITS-1:0]             req_src_host,
   input  logic [HOST_BITS-1:0]             req_dst_host,
   input  logic [HOST_BITS-1:0]             req_link_host,
   input  logic [fts_pkg::FLOW_W-1:0]       req_flow_id,
   input  logic [fts_pkg::PKT_W-1:0]        req_packet_kind,
   input  logic [fts_pkg::SAVED_W-1:0]      req_saved_up,
   input  logic                             req_saved_up_valid,
   input  logic [fts_pkg::SAVED_W-1:0]      req_saved_edge_up,
   input  logic                             req_saved_edge_up_valid,
   input  logic [fts_pkg::HOP_W-1:0]        req_hop_in,
   output logic [fts_pkg::ACTION_W-1:0]     rsp_action,
   output logic [fts_pkg::PORT_W-1:0]       rsp_next_port,
   output logic [fts_pkg::HOP_W-1:0]        rsp_hop_count,
   output logic [fts_pkg::SAVED_W-1:0]      rsp_saved_up_out,
   output logic                             rsp_saved_up_valid_out,
   output logic [fts_pkg::SAVED_W-1:0]      rsp_saved_edge_up_out,
   output logic                             rsp_saved_edge_up_valid_out
);

   localparam int HALF_W  = $clog2(MAX_ARITY / 2 + 1);
   localparam int SPRAY_W = $clog2(MAX_ARITY / 2);
   localparam int QI_W    = $clog2(NUM_QUEUES);
   localparam int STEPS_B = (HOST_BITS + 1) / 2;
   localparam int SHIFT_B = fts_pkg::SUM_W - 2 * STEPS_B;
   localparam int MAX_K   = (MAX_ARITY / 2) * 2;
   localparam int SUM_W   = fts_pkg::SUM_W;
   localparam int NLANES  = fts_pkg::NLANES;
   localparam int SAVED_W = fts_pkg::SAVED_W;
   localparam int PICK_W  = HALF_W + SAVED_W + 1;

   // configuration
   logic [fts_pkg::ARITY_W-1:0] arity_ff;
   logic [fts_pkg::MODE_W-1:0]  mode_ff;

   // captured item
   logic [fts_pkg::KIND_W-1:0]  kind_ff;
   logic [QI_W-1:0]             qidx_ff;
   logic [HOST_BITS-1:0]        src_ff, dst_ff, lhost_ff;
   logic [fts_pkg::FLOW_W-1:0]  flow_ff;
   logic [fts_pkg::PKT_W-1:0]   pkind_ff;
   logic [SAVED_W-1:0]          sv_ff, se_ff;
   logic                        svv_ff, sev_ff;
   logic [fts_pkg::HOP_W-1:0]   hop_ff;
   logic [HALF_W-1:0]           half_ff, half_calc;

   // divider lanes and saved first-pass results
   logic [SUM_W-1:0]  q_ff [NLANES];
   logic [SUM_W-1:0]  q_in [NLANES];
   logic [SUM_W-1:0]  q_step [NLANES];
   logic [HALF_W-1:0] r_ff [NLANES];
   logic [HALF_W-1:0] r_in [NLANES];
   logic [HALF_W-1:0] r_step [NLANES];
   logic [HOST_BITS-1:0] qs_ff, qd_ff;
   logic [HALF_W-1:0]    rd_ff, sumrem_ff, sprayrem_ff;

   // spray counter memory
   logic [QI_W-1:0]    clr_addr_ff;
   logic               ram_wr_en;
   logic [QI_W-1:0]    ram_wr_addr;
   logic [SPRAY_W-1:0] ram_wr_data, ram_rd_data, spray_next;
   logic [HALF_W:0]    spray_inc;

   // result
   logic [fts_pkg::ACTION_W-1:0] act_in, act_ff;
   logic [fts_pkg::PORT_W-1:0]   port_in, port_ff;
   logic [fts_pkg::HOP_W-1:0]    hopo_in, hopo_ff, expect_hop;
   logic [SAVED_W-1:0]           svo_in, svo_ff, seo_in, seo_ff;
   logic                         svvo_in, svvo_ff, sevo_in, sevo_ff;
   logic                         use_pick;
   logic                         same_rack, same_pod;
   logic [HOST_BITS-1:0]         qqd;
   logic [HALF_W-1:0]            rqd;
   logic [PICK_W-1:0]            pick_host, pick_edge;
   logic [HALF_W-1:0]            ch_host, ch_edge;
   logic [HALF_W:0]              up_host, up_edge;

   function automatic logic [PICK_W-1:0] pick(
      input logic [SAVED_W-1:0]        sv,
      input logic                      svv,
      input logic [HALF_W-1:0]         half,
      input logic [fts_pkg::MODE_W-1:0] mode,
      input logic [HALF_W-1:0]         spray,
      input logic [HALF_W-1:0]         sumrem,
      input logic [fts_pkg::PKT_W-1:0] pkind
   );
      logic [HALF_W-1:0]  choice;
      logic [SAVED_W-1:0] sv_o;
      logic               svv_o;
      choice = '0;
      case (mode)
         fts_pkg::MODE_SPRAY: choice = spray;
         fts_pkg::MODE_HASH:  choice = sumrem;
         fts_pkg::MODE_SAVED: begin
            if (svv && (int'(sv) < int'(half))) begin
               choice = HALF_W'(sv);
            end
         end
         default: choice = '0;
      endcase
      sv_o  = sv;
      svv_o = svv;
      if (pkind == fts_pkg::PKT_PROBE) begin
         sv_o  = SAVED_W'(choice);
         svv_o = 1'b1;
      end else if ((pkind == fts_pkg::PKT_DATA) && svv) begin
         choice = (int'(sv) < int'(half)) ? HALF_W'(sv) : '0;
      end
      return {choice, sv_o, svv_o};
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arity_ff <= fts_pkg::ARITY_RESET;
         mode_ff  <= fts_pkg::MODE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fts_pkg::CSR_ARITY: arity_ff <= csr_wr_data[fts_pkg::ARITY_W-1:0];
            fts_pkg::CSR_MODE:  mode_ff  <= csr_wr_data[fts_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective k/2 from the arity register
   always_comb begin
      int k;
      k = int'({arity_ff[fts_pkg::ARITY_W-1:1], 1'b0});
      if (k < 4) k = 4;
      if (k > MAX_K) k = MAX_K;
      half_calc = HALF_W'(k >> 1);
   end

   // capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_link_kind;
         qidx_ff  <= QI_W'(req_queue_id);
         src_ff   <= req_src_host;
         dst_ff   <= req_dst_host;
         lhost_ff <= req_link_host;
         flow_ff  <= req_flow_id;
         pkind_ff <= req_packet_kind;
         sv_ff    <= req_saved_up;
         svv_ff   <= req_saved_up_valid;
         se_ff    <= req_saved_edge_up;
         sev_ff   <= req_saved_edge_up_valid;
         hop_ff   <= req_hop_in;
         half_ff  <= half_calc;
      end
   end

   // two restoring division steps per cycle on every lane, taken while cmd.step is set
   always_comb begin
      logic [HALF_W:0]   t;
      logic [HALF_W-1:0] r;
      logic [SUM_W-1:0]  q;
      logic              ge;
      for (int l = 0; l < NLANES; l++) begin
         r = r_ff[l];
         q = q_ff[l];
         for (int s = 0; s < 2; s++) begin
            t  = {r, q[SUM_W-1]};
            ge = (t >= {1'b0, half_ff});
            if (ge) begin
               t = t - {1'b0, half_ff};
            end
            r = t[HALF_W-1:0];
            q = {q[SUM_W-2:0], ge};
         end
         q_step[l] = q;
         r_step[l] = r;
      end
   end

   always_comb begin
      for (int l = 0; l < NLANES; l++) begin
         q_in[l] = q_ff[l];
         r_in[l] = r_ff[l];
      end
      if (cmd.load_a) begin
         q_in[0] = SUM_W'(src_ff);
         q_in[1] = SUM_W'(dst_ff);
         q_in[2] = SUM_W'(src_ff) + SUM_W'(dst_ff) + SUM_W'(flow_ff);
         q_in[3] = SUM_W'(ram_rd_data);
         for (int l = 0; l < NLANES; l++) begin
            r_in[l] = '0;
         end
      end else if (cmd.load_b) begin
         q_in[0] = SUM_W'(q_ff[0][HOST_BITS-1:0]) << SHIFT_B;
         q_in[1] = SUM_W'(q_ff[1][HOST_BITS-1:0]) << SHIFT_B;
         for (int l = 0; l < NLANES; l++) begin
            r_in[l] = '0;
         end
      end else if (cmd.step) begin
         for (int l = 0; l < NLANES; l++) begin
            q_in[l] = q_step[l];
            r_in[l] = r_step[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NLANES; l++) begin
         q_ff[l] <= q_in[l];
         r_ff[l] <= r_in[l];
      end
      if (cmd.load_b) begin
         qs_ff       <= q_ff[0][HOST_BITS-1:0];
         qd_ff       <= q_ff[1][HOST_BITS-1:0];
         rd_ff       <= r_ff[1];
         sumrem_ff   <= r_ff[2];
         sprayrem_ff <= r_ff[3];
      end
   end

   // rack and pod compare after the second pass
   assign same_rack = (qs_ff == qd_ff);
   assign same_pod  = (q_ff[0][HOST_BITS-1:0] == q_ff[1][HOST_BITS-1:0]);
   assign qqd       = q_ff[1][HOST_BITS-1:0];
   assign rqd       = r_ff[1];
   assign expect_hop = same_rack ? fts_pkg::HOP_RACK :
                       (same_pod ? fts_pkg::HOP_POD : fts_pkg::HOP_CORE);

   assign pick_host = pick(sv_ff, svv_ff, half_ff, mode_ff, sprayrem_ff, sumrem_ff, pkind_ff);
   assign pick_edge = pick(se_ff, sev_ff, half_ff, mode_ff, sprayrem_ff, sumrem_ff, pkind_ff);
   assign ch_host   = pick_host[PICK_W-1 -: HALF_W];
   assign ch_edge   = pick_edge[PICK_W-1 -: HALF_W];
   assign up_host   = {1'b0, half_ff} + {1'b0, ch_host};
   assign up_edge   = {1'b0, half_ff} + {1'b0, ch_edge};

   always_comb begin
      act_in   = fts_pkg::ACT_FORWARD;
      port_in  = '0;
      hopo_in  = hop_ff;
      svo_in   = sv_ff;
      svvo_in  = svv_ff;
      seo_in   = se_ff;
      sevo_in  = sev_ff;
      use_pick = 1'b0;
      unique case (kind_ff)
         fts_pkg::LINK_HOST_EDGE: begin
            hopo_in = expect_hop;
            if (same_rack) begin
               port_in = fts_pkg::PORT_W'(rd_ff);
            end else begin
               port_in  = fts_pkg::PORT_W'(up_host);
               svo_in   = pick_host[SAVED_W:1];
               svvo_in  = pick_host[0];
               use_pick = 1'b1;
            end
         end
         fts_pkg::LINK_EDGE_AGG: begin
            if (same_pod) begin
               port_in = fts_pkg::PORT_W'(rqd);
            end else begin
               port_in  = fts_pkg::PORT_W'(up_edge);
               seo_in   = pick_edge[SAVED_W:1];
               sevo_in  = pick_edge[0];
               use_pick = 1'b1;
            end
         end
         fts_pkg::LINK_EDGE_HOST: begin
            if (dst_ff != lhost_ff) begin
               act_in = fts_pkg::ACT_MISMATCH;
            end else if (hop_ff != expect_hop) begin
               act_in = fts_pkg::ACT_HOP_ERR;
            end else begin
               act_in = fts_pkg::ACT_ARRIVED;
            end
         end
         fts_pkg::LINK_AGG_EDGE: port_in = fts_pkg::PORT_W'(rd_ff);
         fts_pkg::LINK_AGG_CORE: port_in = fts_pkg::PORT_W'(qqd);
         fts_pkg::LINK_CORE_AGG: port_in = fts_pkg::PORT_W'(rqd);
         default: act_in = fts_pkg::ACT_HOP_ERR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         act_ff  <= act_in;
         port_ff <= port_in;
         hopo_ff <= hopo_in;
         svo_ff  <= svo_in;
         svvo_ff <= svvo_in;
         seo_ff  <= seo_in;
         sevo_ff <= sevo_in;
      end
   end

   // spray counter advance and clearing pass
   assign spray_inc  = {1'b0, sprayrem_ff} + 1'b1;
   assign spray_next = (spray_inc == {1'b0, half_ff}) ? '0 : SPRAY_W'(spray_inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_addr_ff == QI_W'(NUM_QUEUES - 1));

   assign ram_wr_en   = cmd.clear ||
                        (cmd.finish && use_pick && (mode_ff == fts_pkg::MODE_SPRAY));
   assign ram_wr_addr = cmd.clear ? clr_addr_ff : qidx_ff;
   assign ram_wr_data = cmd.clear ? '0 : spray_next;

   fts_ram #(
      .WIDTH (SPRAY_W),
      .DEPTH (NUM_QUEUES)
   ) u_spray_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (QI_W'(req_queue_id)),
      .rd_data (ram_rd_data)
   );

   assign rsp_action                  = act_ff;
   assign rsp_next_port               = port_ff;
   assign rsp_hop_count               = hopo_ff;
   assign rsp_saved_up_out            = svo_ff;
   assign rsp_saved_up_valid_out      = svvo_ff;
   assign rsp_saved_edge_up_out       = seo_ff;
   assign rsp_saved_edge_up_valid_out = sevo_ff;

endmodule

[sv/fat_tree_next_port_select.sv]
// ----------------------------------------------------------------------------
// fat_tree_next_port_select
// Next-port selection for one packet on one link of a k-ary fat tree.
// ----------------------------------------------------------------------------
// sequence: capture, the two passes of the radix-4 divider by k/2, then the
//    result registers are loaded and rsp_valid raised once the output is free
// items: one at a time; req_ready is high only when idle, once the previous result is loaded
// reset: clears all NUM_QUEUES entries of the spray counter memory, one entry
//    a cycle, while req_ready stays low
// ----------------------------------------------------------------------------
module fat_tree_next_port_select #(
   parameter int MAX_ARITY  = fts_pkg::MAX_ARITY_DEF,
   parameter int NUM_QUEUES = fts_pkg::NUM_QUEUES_DEF,
   parameter int HOST_BITS  = fts_pkg::HOST_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [fts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fts_pkg::KIND_W-1:0]     req_link_kind,
   input  logic [fts_pkg::QUEUE_W-1:0]    req_queue_id,
   input  logic [HOST_BITS-1:0]           req_src_host,
   input  logic [HOST_BITS-1:0]           req_dst_host,
   input  logic [HOST_BITS-1:0]           req_link_host,
   input  logic [fts_pkg::FLOW_W-1:0]     req_flow_id,
   input  logic [fts_pkg::PKT_W-1:0]      req_packet_kind,
   input  logic [fts_pkg::SAVED_W-1:0]    req_saved_up,
   input  logic                           req_saved_up_valid,
   input  logic [fts_pkg::SAVED_W-1:0]    req_saved_edge_up,
   input  logic                           req_saved_edge_up_valid,
   input  logic [fts_pkg::HOP_W-1:0]      req_hop_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fts_pkg::ACTION_W-1:0]   rsp_action,
   output logic [fts_pkg::PORT_W-1:0]     rsp_next_port,
   output logic [fts_pkg::HOP_W-1:0]      rsp_hop_count,
   output logic [fts_pkg::SAVED_W-1:0]    rsp_saved_up_out,
   output logic                           rsp_saved_up_valid_out,
   output logic [fts_pkg::SAVED_W-1:0]    rsp_saved_edge_up_out,
   output logic                           rsp_saved_edge_up_valid_out
);

   fts_pkg::cmd_type    cmd;
   fts_pkg::status_type status;

   fts_ctrl #(
      .HOST_BITS (HOST_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fts_dpath #(
      .MAX_ARITY  (MAX_ARITY),
      .NUM_QUEUES (NUM_QUEUES),
      .HOST_BITS  (HOST_BITS)
   ) u_dpath (
      .clock                       (clock),
      .reset                       (reset),
      .cmd                         (cmd),
      .status                      (status),
      .csr_wr_en                   (csr_wr_en),
      .csr_index                   (csr_index),
      .csr_wr_data                 (csr_wr_data),
      .req_link_kind               (req_link_kind),
      .req_queue_id                (req_queue_id),
      .req_src_host                (req_src_host),
      .req_dst_host                (req_dst_host),
      .req_link_host               (req_link_host),
      .req_flow_id                 (req_flow_id),
      .req_packet_kind             (req_packet_kind),
      .req_saved_up                (req_saved_up),
      .req_saved_up_valid          (req_saved_up_valid),
      .req_saved_edge_up           (req_saved_edge_up),
      .req_saved_edge_up_valid     (req_saved_edge_up_valid),
      .req_hop_in                  (req_hop_in),
      .rsp_action                  (rsp_action),
      .rsp_next_port               (rsp_next_port),
      .rsp_hop_count               (rsp_hop_count),
      .rsp_saved_up_out            (rsp_saved_up_out),
      .rsp_saved_up_valid_out      (rsp_saved_up_valid_out),
      .rsp_saved_edge_up_out       (rsp_saved_edge_up_out),
      .rsp_saved_edge_up_valid_out (rsp_saved_edge_up_valid_out)
   );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the fat tree next port selector. A short table
// of directed packets is followed by random traffic over several tree sizes
// and balance modes. Every result transfer is compared field by field, in
// order, with a typed table route or a behavioral model of port selection.
// ----------------------------------------------------------------------------
module tb;

   localparam int HOST_BITS   = fts_pkg::HOST_BITS_DEF;
   localparam int NUM_QUEUES  = fts_pkg::NUM_QUEUES_DEF;
   localparam int MAX_ARITY   = fts_pkg::MAX_ARITY_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_PHASES  = 12;
   localparam int PHASE_ITEMS = 125;
   localparam int TAIL_CYCLES = 30;

   localparam logic [fts_pkg::KIND_W-1:0] LINK_UNUSED_6 = 3'd6;
   localparam logic [fts_pkg::KIND_W-1:0] LINK_UNUSED_7 = 3'd7;
   localparam logic [fts_pkg::PKT_W-1:0]  PKT_PROBE_ACK = 2'd1;
   localparam logic [fts_pkg::PKT_W-1:0]  PKT_DATA_ACK  = 2'd3;

   typedef struct packed {
      logic [fts_pkg::KIND_W-1:0]  link_kind;
      logic [fts_pkg::QUEUE_W-1:0] queue_id;
      logic [HOST_BITS-1:0]        src_host;
      logic [HOST_BITS-1:0]        dst_host;
      logic [HOST_BITS-1:0]        link_host;
      logic [fts_pkg::FLOW_W-1:0]  flow_id;
      logic [fts_pkg::PKT_W-1:0]   packet_kind;
      logic [fts_pkg::SAVED_W-1:0] saved_up;
      logic                        saved_up_valid;
      logic [fts_pkg::SAVED_W-1:0] saved_edge_up;
      logic                        saved_edge_up_valid;
      logic [fts_pkg::HOP_W-1:0]   hop_in;
   } packet_type;

   typedef struct packed {
      logic [fts_pkg::ACTION_W-1:0] action;
      logic [fts_pkg::PORT_W-1:0]   next_port;
      logic [fts_pkg::HOP_W-1:0]    hop_count;
      logic [fts_pkg::SAVED_W-1:0]  saved_up;
      logic                         saved_up_valid;
      logic [fts_pkg::SAVED_W-1:0]  saved_edge_up;
      logic                         saved_edge_up_valid;
   } route_type;

   typedef struct packed {
      logic [fts_pkg::ARITY_W-1:0] arity;
      logic [fts_pkg::MODE_W-1:0]  mode;
      packet_type                  pkt;
      logic                        typed;
      route_type                   want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [fts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fts_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [fts_pkg::KIND_W-1:0] req_link_kind = '0;
   logic [fts_pkg::QUEUE_W-1:0] req_queue_id = '0;
   logic [HOST_BITS-1:0] req_src_host = '0;
   logic [HOST_BITS-1:0] req_dst_host = '0;
   logic [HOST_BITS-1:0] req_link_host = '0;
   logic [fts_pkg::FLOW_W-1:0] req_flow_id = '0;
   logic [fts_pkg::PKT_W-1:0] req_packet_kind = '0;
   logic [fts_pkg::SAVED_W-1:0] req_saved_up = '0;
   logic req_saved_up_valid = 1'b0;
   logic [fts_pkg::SAVED_W-1:0] req_saved_edge_up = '0;
   logic req_saved_edge_up_valid = 1'b0;
   logic [fts_pkg::HOP_W-1:0] req_hop_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [fts_pkg::ACTION_W-1:0] rsp_action;
   logic [fts_pkg::PORT_W-1:0] rsp_next_port;
   logic [fts_pkg::HOP_W-1:0] rsp_hop_count;
   logic [fts_pkg::SAVED_W-1:0] rsp_saved_up_out;
   logic rsp_saved_up_valid_out;
   logic [fts_pkg::SAVED_W-1:0] rsp_saved_edge_up_out;
   logic rsp_saved_edge_up_valid_out;

   // model state
   logic [fts_pkg::ARITY_W-1:0] arity_model = fts_pkg::ARITY_RESET;
   logic [fts_pkg::MODE_W-1:0]  mode_model  = fts_pkg::MODE_RESET;
   logic [fts_pkg::SAVED_W-1:0] spray_model [NUM_QUEUES];

   route_type pending_routes [$];
   table_row_type directed_rows [25];
   int unsigned error_count = 0;
   logic sender_calm = 1'b0;

   always #10 clock = ~clock;

   fat_tree_next_port_select DUT (
      .clock                       (clock),
      .reset                       (reset),
      .csr_wr_en                   (csr_wr_en),
      .csr_index                   (csr_index),
      .csr_wr_data                 (csr_wr_data),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_link_kind               (req_link_kind),
      .req_queue_id                (req_queue_id),
      .req_src_host                (req_src_host),
      .req_dst_host                (req_dst_host),
      .req_link_host               (req_link_host),
      .req_flow_id                 (req_flow_id),
      .req_packet_kind             (req_packet_kind),
      .req_saved_up                (req_saved_up),
      .req_saved_up_valid          (req_saved_up_valid),
      .req_saved_edge_up           (req_saved_edge_up),
      .req_saved_edge_up_valid     (req_saved_edge_up_valid),
      .req_hop_in                  (req_hop_in),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_action                  (rsp_action),
      .rsp_next_port               (rsp_next_port),
      .rsp_hop_count               (rsp_hop_count),
      .rsp_saved_up_out            (rsp_saved_up_out),
      .rsp_saved_up_valid_out      (rsp_saved_up_valid_out),
      .rsp_saved_edge_up_out       (rsp_saved_edge_up_out),
      .rsp_saved_edge_up_valid_out (rsp_saved_edge_up_valid_out)
   );

   function automatic int unsigned half_of(logic [fts_pkg::ARITY_W-1:0] k_raw);
      int unsigned k;
      k = 32'(k_raw & 5'h1E);
      if (k < 4) k = 4;
      if (k > MAX_ARITY) k = MAX_ARITY & 32'hFFFF_FFFE;
      return k / 2;
   endfunction

   function automatic logic [fts_pkg::HOP_W-1:0] expected_hops(int unsigned src,
                                                               int unsigned dst,
                                                               int unsigned half);
      if (src / half == dst / half) return fts_pkg::HOP_RACK;
      if (src / (half * half) == dst / (half * half)) return fts_pkg::HOP_POD;
      return fts_pkg::HOP_CORE;
   endfunction

   function automatic int unsigned saved_or_zero(int unsigned val, logic ok,
                                                 int unsigned half);
      return (ok && val < half) ? val : 0;
   endfunction

   function automatic int unsigned pick_uplink(input logic [fts_pkg::QUEUE_W-1:0] qi,
                                               input logic [31:0] sum,
                                               input logic [fts_pkg::PKT_W-1:0] pkt,
                                               input int unsigned half,
                                               inout logic [fts_pkg::SAVED_W-1:0] sv,
                                               inout logic sv_ok);
      int unsigned choice;
      int unsigned c;
      choice = 0;
      case (mode_model)
         fts_pkg::MODE_SPRAY: begin
            c = spray_model[qi] % half;
            choice = c;
            spray_model[qi] = (c + 1 == half) ? 3'd0 : 3'(c + 1);
         end
         fts_pkg::MODE_HASH: choice = sum % half;
         fts_pkg::MODE_SAVED: choice = saved_or_zero(sv, sv_ok, half);
         default: choice = 0;
      endcase
      if (pkt == fts_pkg::PKT_PROBE) begin
         sv = 3'(choice);
         sv_ok = 1'b1;
      end else if (pkt == fts_pkg::PKT_DATA && sv_ok) begin
         choice = saved_or_zero(sv, 1'b1, half);
      end
      return choice;
   endfunction

   function automatic route_type predict_route(packet_type p);
      route_type r;
      int unsigned half;
      int unsigned pod;
      int unsigned port;
      logic [31:0] sum;
      logic same_rack;
      logic same_pod;
      half = half_of(arity_model);
      pod = half * half;
      same_rack = (p.src_host / half) == (p.dst_host / half);
      same_pod = (p.src_host / pod) == (p.dst_host / pod);
      sum = p.src_host + p.dst_host + p.flow_id;
      port = 0;
      r.action = fts_pkg::ACT_FORWARD;
      r.hop_count = p.hop_in;
      r.saved_up = p.saved_up;
      r.saved_up_valid = p.saved_up_valid;
      r.saved_edge_up = p.saved_edge_up;
      r.saved_edge_up_valid = p.saved_edge_up_valid;
      case (p.link_kind)
         fts_pkg::LINK_HOST_EDGE: begin
            r.hop_count = expected_hops(p.src_host, p.dst_host, half);
            if (same_rack) port = p.dst_host % half;
            else port = half + pick_uplink(p.queue_id, sum, p.packet_kind, half,
                                           r.saved_up, r.saved_up_valid);
         end
         fts_pkg::LINK_EDGE_AGG: begin
            if (same_pod) port = (p.dst_host / half) % half;
            else port = half + pick_uplink(p.queue_id, sum, p.packet_kind, half,
                                           r.saved_edge_up, r.saved_edge_up_valid);
         end
         fts_pkg::LINK_EDGE_HOST: begin
            if (p.dst_host != p.link_host) r.action = fts_pkg::ACT_MISMATCH;
            else if (p.hop_in != expected_hops(p.src_host, p.dst_host, half))
               r.action = fts_pkg::ACT_HOP_ERR;
            else r.action = fts_pkg::ACT_ARRIVED;
         end
         fts_pkg::LINK_AGG_EDGE: port = p.dst_host % half;
         fts_pkg::LINK_AGG_CORE: port = p.dst_host / pod;
         fts_pkg::LINK_CORE_AGG: port = (p.dst_host / half) % half;
         default: r.action = fts_pkg::ACT_HOP_ERR;
      endcase
      r.next_port = port[fts_pkg::PORT_W-1:0];
      return r;
   endfunction

   function automatic packet_type random_packet(int unsigned half);
      packet_type p;
      logic [95:0] raw;
      int unsigned pod;
      int unsigned dst;
      int unsigned r;
      pod = half * half;
      raw = {$urandom(), $urandom(), $urandom()};
      p = raw[$bits(packet_type)-1:0];
      if ($urandom_range(0, 99) < 15) return p;
      r = $urandom_range(0, 99);
      if (r < 30) p.link_kind = fts_pkg::LINK_HOST_EDGE;
      else if (r < 55) p.link_kind = fts_pkg::LINK_EDGE_AGG;
      else if (r < 75) p.link_kind = fts_pkg::LINK_EDGE_HOST;
      else if (r < 97) p.link_kind = 3'($urandom_range(3, 5));
      else p.link_kind = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 1) != 0) p.queue_id = 10'($urandom_range(0, 7));
      case ($urandom_range(0, 2))
         0: dst = (p.src_host / half) * half + $urandom_range(0, half - 1);
         1: dst = (p.src_host / pod) * pod + $urandom_range(0, pod - 1);
         default: dst = p.dst_host;
      endcase
      if (dst < (1 << HOST_BITS)) p.dst_host = 10'(dst);
      if ($urandom_range(0, 3) != 0)
         p.packet_kind = ($urandom_range(0, 1) != 0) ? fts_pkg::PKT_PROBE :
                                                       fts_pkg::PKT_DATA;
      if ($urandom_range(0, 3) != 0) p.saved_up = 3'($urandom_range(0, half - 1));
      if ($urandom_range(0, 3) != 0) p.saved_edge_up = 3'($urandom_range(0, half - 1));
      if (p.link_kind == fts_pkg::LINK_EDGE_HOST) begin
         if ($urandom_range(0, 4) != 0) p.link_host = p.dst_host;
         if ($urandom_range(0, 3) != 0)
            p.hop_in = expected_hops(p.src_host, p.dst_host, half);
      end
      if ($urandom_range(0, 19) == 0) p.flow_id = '1;
      return p;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic offer_packet(input packet_type p, input logic typed,
                               input route_type typed_route);
      int unsigned gap;
      route_type predicted;
      gap = 0;
      if (!sender_calm && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_link_kind, req_queue_id, req_src_host, req_dst_host, req_link_host,
       req_flow_id, req_packet_kind, req_saved_up, req_saved_up_valid,
       req_saved_edge_up, req_saved_edge_up_valid, req_hop_in} <= p;
      do @(posedge clock); while (!req_ready);
      predicted = predict_route(p);
      pending_routes.insert(pending_routes.size(), typed ? typed_route : predicted);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_routes.size() != 0);
   endtask

   task automatic program_tree(input logic [fts_pkg::ARITY_W-1:0] k,
                               input logic [fts_pkg::MODE_W-1:0] m);
      csr_wr_en <= 1'b1;
      csr_index <= fts_pkg::CSR_ARITY;
      csr_wr_data <= k;
      @(posedge clock);
      csr_index <= fts_pkg::CSR_MODE;
      csr_wr_data <= 5'(m);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      arity_model = k;
      mode_model = m;
   endtask

   // result side: random stalls, one long hold-off, one calm stretch
   initial begin
      route_type got;
      route_type want;
      int unsigned results_seen;
      int unsigned hold_left;
      logic next_ready;
      results_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_action, rsp_next_port, rsp_hop_count, rsp_saved_up_out,
                   rsp_saved_up_valid_out, rsp_saved_edge_up_out,
                   rsp_saved_edge_up_valid_out};
            if (pending_routes.size() == 0) begin
               $error("result transfer with no packet outstanding");
               error_count++;
            end else begin
               want = pending_routes.pop_front();
               check_field("action", want.action, got.action);
               check_field("next_port", want.next_port, got.next_port);
               check_field("hop_count", want.hop_count, got.hop_count);
               check_field("saved_up_out", want.saved_up, got.saved_up);
               check_field("saved_up_valid_out", want.saved_up_valid, got.saved_up_valid);
               check_field("saved_edge_up_out", want.saved_edge_up, got.saved_edge_up);
               check_field("saved_edge_up_valid_out", want.saved_edge_up_valid,
                           got.saved_edge_up_valid);
            end
            results_seen++;
            if (results_seen == 200) hold_left = 500;
         end
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (results_seen >= 600 && results_seen < 800) begin
            next_ready = 1'b1;
         end else begin
            next_ready = ($urandom_range(0, 99) >= 20);
         end
         rsp_ready <= next_ready;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      table_row_type row;
      logic [fts_pkg::ARITY_W-1:0] k;
      logic [fts_pkg::MODE_W-1:0] m;
      int unsigned item_count;
      foreach (spray_model[i]) spray_model[i] = '0;
      item_count = 0;
      directed_rows = '{
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 0, 0, 1, 0, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 0},
           1, '{fts_pkg::ACT_FORWARD, 1, fts_pkg::HOP_RACK, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 1023, 0, 1023, 0, 0, fts_pkg::PKT_PROBE,
             0, 0, 0, 0, 0},
           1, '{fts_pkg::ACT_FORWARD, 2, fts_pkg::HOP_CORE, 0, 1, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 1023, 0, 1023, 0, 0, fts_pkg::PKT_PROBE,
             7, 0, 7, 1, 0},
           1, '{fts_pkg::ACT_FORWARD, 3, fts_pkg::HOP_CORE, 1, 1, 7, 1}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_HOST, 0, 0, 5, 6, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 0},
           1, '{fts_pkg::ACT_MISMATCH, 0, 0, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_HOST, 0, 5, 5, 5, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 3},
           1, '{fts_pkg::ACT_HOP_ERR, 0, 3, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_HOST, 0, 4, 5, 5, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0,
             fts_pkg::HOP_RACK},
           1, '{fts_pkg::ACT_ARRIVED, 0, fts_pkg::HOP_RACK, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{LINK_UNUSED_6, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF,
             PKT_DATA_ACK, 7, 1, 7, 1, 7},
           1, '{fts_pkg::ACT_HOP_ERR, 0, 7, 7, 1, 7, 1}},
         '{4, fts_pkg::MODE_SPRAY,
           '{LINK_UNUSED_7, 0, 0, 0, 0, 0, fts_pkg::PKT_PROBE, 0, 0, 0, 0, 0},
           1, '{fts_pkg::ACT_HOP_ERR, 0, 0, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_AGG_CORE, 0, 0, 1023, 0, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 5},
           1, '{fts_pkg::ACT_FORWARD, 15, 5, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_AGG_EDGE, 0, 0, 1023, 0, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 1},
           1, '{fts_pkg::ACT_FORWARD, 1, 1, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_CORE_AGG, 0, 0, 1022, 0, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 0},
           1, '{fts_pkg::ACT_FORWARD, 1, 0, 0, 0, 0, 0}},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_AGG, 5, 0, 3, 0, 0, fts_pkg::PKT_DATA, 0, 0, 0, 0, 4},
           0, '0},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_AGG, 5, 0, 1023, 0, 0, fts_pkg::PKT_PROBE, 0, 0, 5, 0, 6},
           0, '0},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 5, 0, 1023, 0, 0, fts_pkg::PKT_DATA, 1, 1, 0, 0, 0},
           0, '0},
         '{4, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 5, 0, 1023, 0, 0, fts_pkg::PKT_DATA, 5, 1, 0, 0, 0},
           0, '0},
         '{4, fts_pkg::MODE_HASH,
           '{fts_pkg::LINK_HOST_EDGE, 7, 1023, 0, 0, 32'hFFFF_FFFF, PKT_PROBE_ACK,
             0, 0, 0, 0, 0},
           0, '0},
         '{16, fts_pkg::MODE_HASH,
           '{fts_pkg::LINK_EDGE_AGG, 7, 1, 1000, 0, 32'h8000_0001, PKT_DATA_ACK,
             0, 0, 3, 1, 0},
           0, '0},
         '{16, fts_pkg::MODE_SAVED,
           '{fts_pkg::LINK_HOST_EDGE, 0, 0, 1023, 0, 0, PKT_DATA_ACK, 7, 1, 0, 0, 0},
           0, '0},
         '{16, fts_pkg::MODE_SAVED,
           '{fts_pkg::LINK_HOST_EDGE, 0, 0, 1023, 0, 0, fts_pkg::PKT_PROBE, 3, 0, 0, 0, 0},
           0, '0},
         '{0, fts_pkg::MODE_SAVED,
           '{fts_pkg::LINK_HOST_EDGE, 0, 0, 1023, 0, 0, PKT_DATA_ACK, 3, 1, 0, 0, 0},
           0, '0},
         '{3, fts_pkg::MODE_ZERO,
           '{fts_pkg::LINK_EDGE_AGG, 0, 0, 1023, 0, 0, fts_pkg::PKT_PROBE, 0, 0, 6, 1, 0},
           0, '0},
         '{5, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 2, 0, 1023, 0, 0, fts_pkg::PKT_PROBE, 0, 0, 0, 0, 0},
           0, '0},
         '{17, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_HOST_EDGE, 1023, 0, 1023, 0, 0, fts_pkg::PKT_PROBE,
             0, 0, 0, 0, 0},
           0, '0},
         '{31, fts_pkg::MODE_SPRAY,
           '{fts_pkg::LINK_EDGE_AGG, 1023, 0, 1023, 0, 0, fts_pkg::PKT_PROBE,
             0, 0, 0, 0, 0},
           0, '0},
         '{6, fts_pkg::MODE_HASH,
           '{fts_pkg::LINK_HOST_EDGE, 9, 0, 1023, 0, 32'h1234_5678, fts_pkg::PKT_DATA,
             0, 0, 0, 0, 0},
           0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.arity != arity_model || row.mode != mode_model) begin
            wait_drained();
            program_tree(row.arity, row.mode);
         end
         offer_packet(row.pkt, row.typed, row.want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin k = 5'd16; m = fts_pkg::MODE_SPRAY; end
            1: begin k = 5'd4; m = fts_pkg::MODE_HASH; end
            2: begin k = 5'd16; m = fts_pkg::MODE_SAVED; end
            3: begin k = 5'd8; m = fts_pkg::MODE_ZERO; end
            default: begin
               if ($urandom_range(0, 3) == 0) k = 5'($urandom_range(0, 31));
               else k = 5'(2 * $urandom_range(2, 8));
               m = 2'($urandom_range(0, 3));
            end
         endcase
         wait_drained();
         program_tree(k, m);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_calm = (item_count >= 600 && item_count < 800);
            offer_packet(random_packet(half_of(k)), 1'b0, '0);
            item_count++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
sv/fts_pkg.sv
sv/fts_ram.sv
sv/fts_ctrl.sv
sv/fts_dpath.sv
sv/fat_tree_next_port_select.sv
sim/tb.sv
